// ----- src/utf8_space_normalizer_top_macros.svh -----
// assertion macros for the utf8 space normalizer checker
// expects clk and arst_n in the scope where a macro is used
`ifndef UTF8_SPACE_NORMALIZER_TOP_MACROS_SVH
`define UTF8_SPACE_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication
`define USN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usn check failed: same-cycle rule");

// next-cycle implication
`define USN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usn check failed: next-cycle rule");

`endif

// ----- src/usn_pkg.sv -----
// shared types, byte constants and match functions for the utf8 space normalizer
// no dependencies
package usn_pkg;

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	// lead bytes of the space sequences
	localparam logic [7:0] LEAD_C2 = 8'hC2;
	localparam logic [7:0] LEAD_E1 = 8'hE1;
	localparam logic [7:0] LEAD_E2 = 8'hE2;
	localparam logic [7:0] LEAD_E3 = 8'hE3;

	// continuation bytes used by the sequences
	localparam logic [7:0] CONT_80 = 8'h80;
	localparam logic [7:0] CONT_81 = 8'h81;
	localparam logic [7:0] CONT_8A = 8'h8A;
	localparam logic [7:0] CONT_9A = 8'h9A;
	localparam logic [7:0] CONT_9F = 8'h9F;
	localparam logic [7:0] CONT_A0 = 8'hA0;
	localparam logic [7:0] CONT_AF = 8'hAF;

	// held byte counts
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	localparam int MAX_BEATS   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} held_t;

	typedef struct packed {
		logic [1:0]                  num;
		beat_t [MAX_BEATS-1:0]       beats;
		held_t                       held;
	} step_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b == LEAD_C2) || (b == LEAD_E1) || (b == LEAD_E2) || (b == LEAD_E3);
	endfunction

	function automatic logic prefix_ok(input logic [7:0] a, input logic [7:0] b);
		return (a == LEAD_E1 && b == CONT_9A) ||
			(a == LEAD_E2 && (b == CONT_80 || b == CONT_81)) ||
			(a == LEAD_E3 && b == CONT_80);
	endfunction

	function automatic logic triple_ok(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if (a == LEAD_E1 && b == CONT_9A) begin
			ok = (c == CONT_80);
		end else if (a == LEAD_E2 && b == CONT_80) begin
			ok = (c >= CONT_80 && c <= CONT_8A) || (c == CONT_AF);
		end else if (a == LEAD_E2 && b == CONT_81) begin
			ok = (c == CONT_9F);
		end else if (a == LEAD_E3 && b == CONT_80) begin
			ok = (c == CONT_80);
		end
		return ok;
	endfunction

endpackage

// ----- src/usn_step.sv -----
// per-byte match logic: from the held prefix and one new byte, the beats to send
// and the next held prefix; uses usn_pkg
module usn_step (
	input  logic [7:0]      data,
	input  logic            last,
	input  usn_pkg::held_t  held,
	output usn_pkg::step_t  res
);
	import usn_pkg::*;

	logic [1:0]            n;
	beat_t [MAX_BEATS-1:0] e;
	held_t                 nh;
	logic                  fresh;

	always_comb begin
		n     = '0;
		e     = '0;
		nh    = '0;
		fresh = 1'b0;
		unique case (held.cnt)
			HELD_NONE: begin
				fresh = 1'b1;
			end
			HELD_ONE: begin
				if (held.b0 == LEAD_C2 && data == CONT_A0) begin
					e[0].data = SPACE_BYTE;
					n         = 2'd1;
				end else if (prefix_ok(held.b0, data)) begin
					nh.cnt = HELD_TWO;
					nh.b0  = held.b0;
					nh.b1  = data;
				end else begin
					e[0].data = held.b0;
					n         = 2'd1;
					fresh     = 1'b1;
				end
			end
			default: begin
				if (triple_ok(held.b0, held.b1, data)) begin
					e[0].data = SPACE_BYTE;
					n         = 2'd1;
				end else begin
					e[0].data = held.b0;
					e[1].data = held.b1;
					n         = 2'd2;
					fresh     = 1'b1;
				end
			end
		endcase

		// new byte looked at again as a possible lead byte
		if (fresh) begin
			if (is_lead(data)) begin
				nh.cnt = HELD_ONE;
				nh.b0  = data;
			end else begin
				e[n].data = data;
				n         = n + 2'd1;
			end
		end

		// end of text: flush whatever is still held
		if (last) begin
			if (nh.cnt != HELD_NONE) begin
				e[n].data = nh.b0;
				n         = n + 2'd1;
			end
			if (nh.cnt == HELD_TWO) begin
				e[n].data = nh.b1;
				n         = n + 2'd1;
			end
			nh = '0;
			if (n != 2'd0) begin
				e[n - 2'd1].last = 1'b1;
			end
		end

		res.num   = n;
		res.beats = e;
		res.held  = nh;
	end

endmodule

// ----- src/usn_outq.sv -----
// small output queue: takes up to three beats per cycle, sends one per cycle while out_stall is low
// uses usn_pkg
module usn_outq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic [1:0]                             push_num,
	input  usn_pkg::beat_t [usn_pkg::MAX_BEATS-1:0] push_beats,
	output logic [usn_pkg::CNT_W-1:0]              avail,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output usn_pkg::beat_t                         out_beat
);
	import usn_pkg::*;

	beat_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [CNT_W-1:0] push_cnt;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_beat  = mem_q[head_q];
	assign push_cnt  = push ? CNT_W'(push_num) : '0;

	// room counts the slot freed by a beat leaving this cycle
	assign avail = CNT_W'(QUEUE_DEPTH) - count_q + CNT_W'(pop);

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_BEATS; i++) begin
				if (2'(i) < push_num) begin
					mem_q[tail_q + PTR_W'(i)] <= push_beats[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			tail_q  <= tail_q + PTR_W'(push_cnt);
			count_q <= count_q + push_cnt - CNT_W'(pop);
		end
	end

endmodule

// ----- src/utf8_space_normalizer_top.sv -----
// top level of the utf8 space normalizer: input register, match step, output queue
// depends on usn_pkg, usn_step, usn_outq
//
//   channel | signals                        | beat
//   --------+--------------------------------+-----------------------------
//   in      | in_valid, in_stall             | in_byte, in_last
//   out     | out_valid, out_stall           | out_byte, out_last
//
// one input byte per cycle while in_stall is low; each byte yields zero to three output beats
// a byte is matched in the cycle after it is taken, its beats are queued when it advances
// in_stall rises only when the four-entry output queue lacks room for the
// beats of the byte in the input register, so out_stall sets the sustained rate
// arst_n clears the held prefix, the input register's valid flag and the queue
module utf8_space_normalizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import usn_pkg::*;

	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             valid_s1;
	held_t            held_q;
	step_t            step;
	logic [CNT_W-1:0] avail;
	logic             adv;
	logic             in_take;
	beat_t            head_beat;

	usn_step u_step (
		.data (byte_s1),
		.last (last_s1),
		.held (held_q),
		.res  (step)
	);

	assign adv      = valid_s1 && (CNT_W'(step.num) <= avail);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_q   <= '0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv);
			if (adv) begin
				held_q <= step.held;
			end
		end
	end

	usn_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (adv),
		.push_num   (step.num),
		.push_beats (step.beats),
		.avail      (avail),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (head_beat)
	);

	assign out_byte = head_beat.data;
	assign out_last = head_beat.last;

endmodule

// ----- src/usn_checker.sv -----
// port-level checks for the utf8 space normalizer, bound to the top level
// depends on utf8_space_normalizer_top_macros.svh
`include "utf8_space_normalizer_top_macros.svh"

module usn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a waiting output beat holds until taken
	`USN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last))
	// an empty output queue always has room, so input never stalls
	`USN_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall)
	// an input stall sits behind queued beats, which stay while output is stalled
	`USN_ASSERT_NEXT(a_stall_keeps_out, in_stall && out_stall, out_valid)

endmodule

bind utf8_space_normalizer_top usn_checker u_usn_checker (.*);

// ----- bench/usn_stream_checker.sv -----
// watches both channels of the utf8 space normalizer, predicts the output text and compares
// depends on usn_pkg for byte constants, held counts and the beat type
`timescale 1ns / 1ps

module usn_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         fail_count,
	output int         pending
);
	import usn_pkg::*;

	beat_t      expected_text[$];
	logic [7:0] prefix_bytes[2];
	logic [1:0] prefix_len;
	int         errors;

	assign fail_count = errors;

	function automatic logic starts_sequence(input logic [7:0] b);
		case (b)
			LEAD_C2, LEAD_E1, LEAD_E2, LEAD_E3: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// prefixes that can still become a three-byte space
	function automatic logic two_byte_prefix(input logic [7:0] a, input logic [7:0] b);
		if (a == LEAD_E1) return b == CONT_9A;
		if (a == LEAD_E2) return b == CONT_80 || b == CONT_81;
		if (a == LEAD_E3) return b == CONT_80;
		return 1'b0;
	endfunction

	function automatic logic three_byte_match(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		if (a == LEAD_E1 && b == CONT_9A) return c == CONT_80;
		if (a == LEAD_E2 && b == CONT_80) return (c >= CONT_80 && c <= CONT_8A) || c == CONT_AF;
		if (a == LEAD_E2 && b == CONT_81) return c == CONT_9F;
		if (a == LEAD_E3 && b == CONT_80) return c == CONT_80;
		return 1'b0;
	endfunction

	task automatic emit_text(input logic [7:0] b);
		beat_t t;
		t.data = b;
		t.last = 1'b0;
		expected_text.push_back(t);
	endtask

	task automatic flush_prefix();
		if (prefix_len >= HELD_ONE) emit_text(prefix_bytes[0]);
		if (prefix_len >= HELD_TWO) emit_text(prefix_bytes[1]);
		prefix_len = HELD_NONE;
		prefix_bytes[0] = 8'h00;
		prefix_bytes[1] = 8'h00;
	endtask

	task automatic take_new(input logic [7:0] b);
		if (starts_sequence(b)) begin
			prefix_bytes[0] = b;
			prefix_len = HELD_ONE;
		end else begin
			emit_text(b);
		end
	endtask

	task automatic settle_byte(input logic [7:0] b, input logic last);
		int start;
		start = expected_text.size();
		case (prefix_len)
			HELD_NONE: begin
				take_new(b);
			end
			HELD_ONE: begin
				if (prefix_bytes[0] == LEAD_C2 && b == CONT_A0) begin
					prefix_len = HELD_NONE;
					prefix_bytes[0] = 8'h00;
					emit_text(SPACE_BYTE);
				end else if (two_byte_prefix(prefix_bytes[0], b)) begin
					prefix_bytes[1] = b;
					prefix_len = HELD_TWO;
				end else begin
					flush_prefix();
					take_new(b);
				end
			end
			default: begin
				if (three_byte_match(prefix_bytes[0], prefix_bytes[1], b)) begin
					prefix_len = HELD_NONE;
					prefix_bytes[0] = 8'h00;
					prefix_bytes[1] = 8'h00;
					emit_text(SPACE_BYTE);
				end else begin
					flush_prefix();
					take_new(b);
				end
			end
		endcase
		if (last) begin
			flush_prefix();
			if (expected_text.size() > start)
				expected_text[expected_text.size() - 1].last = 1'b1;
		end
	endtask

	// output beats are checked before the input beat of the same edge is predicted
	always @(posedge clk) begin
		beat_t want;
		if (!arst_n) begin
			expected_text.delete();
			prefix_len = HELD_NONE;
			prefix_bytes[0] = 8'h00;
			prefix_bytes[1] = 8'h00;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual byte %02h last %b",
						$time, out_byte, out_last);
					errors++;
				end else begin
					want = expected_text.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.data, out_byte);
						errors++;
					end
					if (out_last !== want.last) begin
						$display("%0t: out_last expected %b actual %b",
							$time, want.last, out_last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				settle_byte(in_byte, in_last);
		end
		pending = expected_text.size();
	end

endmodule

// ----- bench/utf8_space_normalizer_top_test.sv -----
// stimulus and verdict for the utf8 space normalizer: directed space sequences, then random text
// depends on usn_pkg, utf8_space_normalizer_top and usn_stream_checker
`timescale 1ns / 1ps

module utf8_space_normalizer_top_test;
	import usn_pkg::*;

	localparam int TEXT_BYTES = 430;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;
	int         fail_count;
	int         pending;
	int         idle_pct;
	int         stall_left;
	int         sent;

	utf8_space_normalizer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	usn_stream_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver stalls in bursts of random length, a burst starting with chance idle_pct percent
	always @(negedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// byte pos of space sequence k: C2 A0, E1 9A 80, E2 80 80..8A, E2 80 AF, E2 81 9F, E3 80 80
	function automatic logic [7:0] seq_byte(input int k, input int pos);
		if (k == 0) return (pos == 0) ? LEAD_C2 : CONT_A0;
		if (k == 1) return (pos == 0) ? LEAD_E1 : (pos == 1) ? CONT_9A : CONT_80;
		if (k == 15) return (pos == 0) ? LEAD_E3 : CONT_80;
		if (pos == 0) return LEAD_E2;
		if (k == 14) return (pos == 1) ? CONT_81 : CONT_9F;
		if (pos == 1) return CONT_80;
		if (k == 13) return CONT_AF;
		return CONT_80 + 8'(k - 2);
	endfunction

	function automatic int seq_len(input int k);
		return (k == 0) ? 2 : 3;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_space(input int k, input logic last);
		for (int pos = 0; pos < seq_len(k); pos++)
			send_byte(seq_byte(k, pos), last && pos == seq_len(k) - 1);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// well-formed spaces, broken prefixes, lone lead bytes and arbitrary bytes
	task automatic send_word();
		int         r;
		int         k;
		int         n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 15);
		if (r < 45) begin
			send_space(k, $urandom_range(0, 11) == 0);
		end else if (r < 65) begin
			n = $urandom_range(1, seq_len(k) - 1);
			for (int pos = 0; pos < n; pos++)
				send_byte(seq_byte(k, pos), $urandom_range(0, 15) == 0);
			case ($urandom_range(0, 3))
				0: b = seq_byte($urandom_range(0, 15), 0);
				1: b = 8'($urandom_range(0, 255));
				default: b = 8'($urandom_range(8'h7F, 8'hB0));
			endcase
			send_byte(b, $urandom_range(0, 11) == 0);
		end else if (r < 80) begin
			send_byte(seq_byte(k, 0), $urandom_range(0, 3) == 0);
		end else begin
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
		end
	endtask

	initial begin
		bit paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		idle_pct = 15;
		sent = 0;
		paused = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// byte extremes, one of each space family, mismatch and flush on last
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_space(0, 1'b0);
		send_space(1, 1'b0);
		send_space(2, 1'b0);
		send_space(12, 1'b0);
		send_space(13, 1'b0);
		send_space(14, 1'b0);
		send_space(15, 1'b1);
		send_byte(LEAD_C2, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(LEAD_E2, 1'b0);
		send_byte(CONT_80, 1'b1);
		hold_until_drained();

		while (sent < TEXT_BYTES) begin
			if (sent > TEXT_BYTES - 60)
				idle_pct = 0;
			else
				case ((sent / 80) % 3)
					0: idle_pct = 12;
					1: idle_pct = 35;
					default: idle_pct = 0;
				endcase
			if (!paused && sent >= TEXT_BYTES / 2) begin
				paused = 1'b1;
				hold_until_drained();
			end
			send_word();
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/usn_pkg.sv
src/usn_step.sv
src/usn_outq.sv
src/utf8_space_normalizer_top.sv
src/usn_checker.sv
bench/usn_stream_checker.sv
bench/utf8_space_normalizer_top_test.sv
